// ===== src/bdot_pkg.sv =====
package bdot_pkg;

  // Fixed field widths
  localparam int AXES       = 3;
  localparam int AXIS_W     = 2;
  localparam int RATE_W     = 16;
  localparam int GAIN_W     = 16;
  localparam int THR_W      = 15;
  localparam int SCALE_W    = 8;
  localparam int DUTY_W     = 16;
  localparam int CNT_W      = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Duty saturation limit, Q1.15
  localparam int DUTY_MAX = 32767;
  localparam logic signed [DUTY_W-1:0] DUTY_POS = 16'sd32767;
  localparam logic signed [DUTY_W-1:0] DUTY_NEG = -16'sd32767;

  // Register reset values
  localparam logic [GAIN_W-1:0]  GAIN_RST  = 16'd8192;
  localparam logic [THR_W-1:0]   THR_RST   = 15'd200;
  localparam logic [SCALE_W-1:0] SCALE_RST = 8'd77;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DUTY_GAIN      = 2'd0,
    REG_RATE_THRESHOLD = 2'd1,
    REG_MISSION_SCALE  = 2'd2
  } cfg_reg_t;

  // Command to the serial multiplier
  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] nbits;
  } mac_cmd_t;

endpackage

// ===== src/bdot_in_if.sv =====
interface bdot_in_if
  import bdot_pkg::*;
#(
  parameter int FIELD_WIDTH = 16
);
  logic                     valid;
  logic                     ready;
  logic signed [FIELD_WIDTH-1:0] field_x;
  logic signed [FIELD_WIDTH-1:0] field_y;
  logic signed [FIELD_WIDTH-1:0] field_z;
  logic signed [RATE_W-1:0] rate_x;
  logic signed [RATE_W-1:0] rate_y;
  logic signed [RATE_W-1:0] rate_z;

  modport source (
    output valid, field_x, field_y, field_z, rate_x, rate_y, rate_z,
    input  ready
  );

  modport sink (
    input  valid, field_x, field_y, field_z, rate_x, rate_y, rate_z,
    output ready
  );
endinterface

// ===== src/bdot_out_if.sv =====
interface bdot_out_if
  import bdot_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [DUTY_W-1:0] duty_x;
  logic signed [DUTY_W-1:0] duty_y;
  logic signed [DUTY_W-1:0] duty_z;
  logic                     mode_now;

  modport source (
    output valid, duty_x, duty_y, duty_z, mode_now,
    input  ready
  );

  modport sink (
    input  valid, duty_x, duty_y, duty_z, mode_now,
    output ready
  );
endinterface

// ===== src/bdot_mac.sv =====
module bdot_mac
  import bdot_pkg::*;
#(
  parameter int MW = 17
) (
  input  logic                           clk,
  input  logic                           rst,
  input  mac_cmd_t                       cmd,
  input  logic signed [MW-1:0]           mcand_in,
  input  logic        [GAIN_W-1:0]       mplier_in,
  output logic                           done,
  output logic signed [MW+GAIN_W-1:0]    product
);

  localparam int PW = MW + GAIN_W;

  logic signed [MW-1:0]     mcand;
  logic        [GAIN_W-1:0] mplier;
  logic        [CNT_W-1:0]  cnt;
  logic signed [PW-1:0]     acc;
  logic signed [PW-1:0]     addend;

  // Add the multiplicand when the current multiplier bit is set
  assign addend  = mplier[GAIN_W-1] ? PW'(mcand) : '0;
  assign product = acc;

  // Shift and add, one multiplier bit per cycle, MSB first
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        acc    <= '0;
        mcand  <= mcand_in;
        mplier <= mplier_in;
        cnt    <= cmd.nbits;
      end else if (cnt != '0) begin
        acc    <= (acc <<< 1) + addend;
        mplier <= mplier << 1;
        cnt    <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== src/bdot_detumble_controller.sv =====
// B-dot detumbling controller. Each request carries three field axes and three
// gyro axes; the block returns one duty triple and the mode after that tick.
// Duty per axis is -(field - previous field) * duty_gain, saturated to +/-32767;
// in mission mode it is further scaled by mission_scale/256 (toward zero). The
// tick on which all gyro axes fall within +/-rate_threshold in detumble mode
// switches to mission and returns zero duty; mission mode is sticky. One item
// is worked at a time: the three axes go in turn through a single shift-add
// multiplier that retires one multiplier bit per cycle: 16 gain bits per axis,
// plus 8 scale bits per axis in mission mode. A finished result sits in the
// output register while the next request is being accepted and worked.
module bdot_detumble_controller
  import bdot_pkg::*;
#(
  parameter int FIELD_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  bdot_in_if.sink               sample,
  bdot_out_if.source            drive
);

  localparam int DW = FIELD_WIDTH + 1;
  localparam int MW = (DW > DUTY_W) ? DW : DUTY_W;
  localparam int PW = MW + GAIN_W;
  localparam logic signed [PW-1:0] LimHi = PW'(DUTY_MAX);
  localparam logic signed [PW-1:0] LimLo = -LimHi;
  localparam logic signed [PW-1:0] RoundAdd = PW'(255);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DIFF  = 7'b0000010,
    S_GAIN  = 7'b0000100,
    S_CLAMP = 7'b0001000,
    S_SCALE = 7'b0010000,
    S_ROUND = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_t;

  state_t state, state_next;

  // Configuration registers
  logic [GAIN_W-1:0]  duty_gain;
  logic [THR_W-1:0]   rate_threshold;
  logic [SCALE_W-1:0] mission_scale;

  // Working rings, entry 0 is the axis in progress
  logic signed [FIELD_WIDTH-1:0] field_ring [AXES];
  logic signed [FIELD_WIDTH-1:0] last_ring  [AXES];
  logic signed [RATE_W-1:0]      rate_ring  [AXES];
  logic signed [DUTY_W-1:0]      duty_ring  [AXES];

  logic [AXIS_W-1:0] axis;
  logic              calm;
  logic              mission;
  logic              mode;

  // Output register
  logic                     out_valid;
  logic signed [DUTY_W-1:0] out_duty [AXES];
  logic                     out_mode;

  // Datapath signals
  logic signed [DW-1:0]     diff;
  logic signed [RATE_W:0]   rate_ext;
  logic signed [RATE_W:0]   thr_ext;
  logic                     rate_pass;
  mac_cmd_t                 mac_cmd;
  logic signed [MW-1:0]     mac_mcand;
  logic [GAIN_W-1:0]        mac_mplier;
  logic                     mac_done;
  logic signed [PW-1:0]     mac_prod;
  logic signed [PW-1:0]     neg_prod;
  logic signed [PW-1:0]     scaled;
  logic signed [DUTY_W-1:0] clamp_duty;
  logic signed [DUTY_W-1:0] store_duty;
  logic                     store;
  logic                     last_axis;
  logic                     load_out;
  logic                     accept;
  logic                     switch_now;

  assign accept    = sample.valid && sample.ready;
  assign last_axis = (axis == AXIS_W'(AXES - 1));
  assign load_out  = (state == S_FIN) && (!out_valid || drive.ready);
  assign switch_now = !mission && calm;

  // Accept a request only between items, never during reset
  assign sample.ready = (state == S_IDLE) && !rst;

  // Drive result ports
  assign drive.valid    = out_valid;
  assign drive.duty_x   = out_duty[0];
  assign drive.duty_y   = out_duty[1];
  assign drive.duty_z   = out_duty[2];
  assign drive.mode_now = out_mode;

  // Field change and gyro threshold test for the current axis
  assign diff      = DW'(field_ring[0]) - DW'(last_ring[0]);
  assign rate_ext  = (RATE_W+1)'(rate_ring[0]);
  assign thr_ext   = signed'({2'b00, rate_threshold});
  assign rate_pass = (rate_ext <= thr_ext) && (rate_ext >= -thr_ext);

  // Negate and saturate the gain product
  assign neg_prod = -mac_prod;
  always_comb begin
    if (mac_prod > LimHi) begin
      clamp_duty = DUTY_NEG;
    end else if (mac_prod < LimLo) begin
      clamp_duty = DUTY_POS;
    end else begin
      clamp_duty = neg_prod[DUTY_W-1:0];
    end
  end

  // Divide the scaled product by 256, truncating toward zero
  assign scaled = mac_prod[PW-1] ? ((mac_prod + RoundAdd) >>> 8) : (mac_prod >>> 8);

  // Feed the shared multiplier: gain pass, then scale pass in mission
  always_comb begin
    mac_cmd.start = 1'b0;
    mac_cmd.nbits = CNT_W'(GAIN_W);
    mac_mcand     = MW'(diff);
    mac_mplier    = duty_gain;
    if (state == S_DIFF) begin
      mac_cmd.start = 1'b1;
    end else if (state == S_CLAMP && mission) begin
      mac_cmd.start = 1'b1;
      mac_cmd.nbits = CNT_W'(SCALE_W);
      mac_mcand     = MW'(clamp_duty);
      mac_mplier    = {mission_scale, {(GAIN_W-SCALE_W){1'b0}}};
    end
  end

  bdot_mac #(
    .MW (MW)
  ) u_mac (
    .clk       (clk),
    .rst       (rst),
    .cmd       (mac_cmd),
    .mcand_in  (mac_mcand),
    .mplier_in (mac_mplier),
    .done      (mac_done),
    .product   (mac_prod)
  );

  // Finish an axis after the gain pass or the scale pass
  always_comb begin
    store      = 1'b0;
    store_duty = clamp_duty;
    if (state == S_CLAMP && !mission) begin
      store = 1'b1;
    end else if (state == S_ROUND) begin
      store      = 1'b1;
      store_duty = scaled[DUTY_W-1:0];
    end
  end

  // Sequence the three axes
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (accept) state_next = S_DIFF;
      S_DIFF:  state_next = S_GAIN;
      S_GAIN:  if (mac_done) state_next = S_CLAMP;
      S_CLAMP: begin
        if (mission) state_next = S_SCALE;
        else if (last_axis) state_next = S_FIN;
        else state_next = S_DIFF;
      end
      S_SCALE: if (mac_done) state_next = S_ROUND;
      S_ROUND: state_next = last_axis ? S_FIN : S_DIFF;
      S_FIN:   if (load_out) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      duty_gain      <= GAIN_RST;
      rate_threshold <= THR_RST;
      mission_scale  <= SCALE_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_DUTY_GAIN:      duty_gain      <= cfg_data[GAIN_W-1:0];
        REG_RATE_THRESHOLD: rate_threshold <= cfg_data[THR_W-1:0];
        REG_MISSION_SCALE:  mission_scale  <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture the request and rotate the rings as axes finish
  always_ff @(posedge clk) begin
    if (accept) begin
      field_ring[0] <= sample.field_x;
      field_ring[1] <= sample.field_y;
      field_ring[2] <= sample.field_z;
      rate_ring[0]  <= sample.rate_x;
      rate_ring[1]  <= sample.rate_y;
      rate_ring[2]  <= sample.rate_z;
    end else if (store) begin
      field_ring[0] <= field_ring[1];
      field_ring[1] <= field_ring[2];
      field_ring[2] <= field_ring[0];
      rate_ring[0]  <= rate_ring[1];
      rate_ring[1]  <= rate_ring[2];
      rate_ring[2]  <= rate_ring[0];
    end
    if (store) begin
      duty_ring[2] <= store_duty;
      duty_ring[1] <= duty_ring[2];
      duty_ring[0] <= duty_ring[1];
    end
  end

  // Advance control: previous field, axis count, calm flag, mode
  always_ff @(posedge clk) begin
    if (rst) begin
      last_ring[0] <= '0;
      last_ring[1] <= '0;
      last_ring[2] <= '0;
      axis         <= '0;
      calm         <= 1'b0;
      mission      <= 1'b0;
      mode         <= 1'b0;
    end else begin
      if (accept) begin
        axis    <= '0;
        calm    <= 1'b1;
        mission <= mode;
      end
      if (state == S_DIFF) begin
        calm <= calm & rate_pass;
      end
      if (store) begin
        last_ring[0] <= last_ring[1];
        last_ring[1] <= last_ring[2];
        last_ring[2] <= field_ring[0];
        axis         <= axis + 1'b1;
      end
      if (load_out && switch_now) begin
        mode <= 1'b1;
      end
    end
  end

  // Hold the result until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (drive.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_duty[0] <= switch_now ? '0 : duty_ring[0];
      out_duty[1] <= switch_now ? '0 : duty_ring[1];
      out_duty[2] <= switch_now ? '0 : duty_ring[2];
      out_mode    <= mission | calm;
    end
  end

endmodule
